@@ hw/rtl/pfc_pkg.sv @@
// Shared types, constants and CRC helpers for the PEC-15 frame checker.
// No dependencies; imported by every module of the block.
package pfc_pkg;

	localparam int MAX_PAYLOAD = 6;
	localparam int MAX_CHAIN   = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [15:0] PEC_POLY = 16'h4599;
	localparam logic [15:0] PEC_SEED = 16'd16;

	localparam logic MODE_CHECK    = 1'b0;
	localparam logic MODE_GENERATE = 1'b1;

	typedef enum logic [1:0] {
		REG_FRAME_MODE    = 2'd0,
		REG_DATA_LENGTH   = 2'd1,
		REG_CHAIN_DEVICES = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic       frame_mode;
		logic [2:0] data_length;
		logic [4:0] chain_devices;
	} cfg_t;

	// result slots carried by one queued request: a whole payload or echo + two PEC bytes
	function automatic int job_slots(input int max_payload);
		return (max_payload > 3) ? max_payload : 3;
	endfunction

	function automatic int job_count_bits(input int max_payload);
		return $clog2(job_slots(max_payload) + 1);
	endfunction

	// layout: {err, dev[3:0], start[2:0], count, bytes}
	function automatic int job_width(input int max_payload);
		return job_slots(max_payload) * 8 + job_count_bits(max_payload) + 8;
	endfunction

	function automatic logic [15:0] pec_entry(input logic [7:0] addr);
		logic [15:0] r;
		r = {1'b0, addr, 7'd0};
		for (int k = 0; k < 8; k++) begin
			if (r[14]) begin
				r = {r[14:0], 1'b0} ^ PEC_POLY;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] addr;
		addr = crc[14:7] ^ b;
		return {crc[7:0], 8'd0} ^ pec_entry(addr);
	endfunction

endpackage

@@ hw/rtl/pfc_front.sv @@
// Front end: takes bytes, runs the PEC-15 remainder and frame counters.
// Emits one queued request per byte that causes results. Uses pfc_pkg.
module pfc_front #(
	parameter int MAX_PAYLOAD = pfc_pkg::MAX_PAYLOAD,
	parameter int MAX_CHAIN   = pfc_pkg::MAX_CHAIN
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  pfc_pkg::cfg_t                            cfg,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [7:0]                               data_byte,
	input  logic                                     chain_start,
	input  logic                                     q_full,
	output logic                                     job_push,
	output logic [pfc_pkg::job_width(MAX_PAYLOAD)-1:0] job_data
);
	import pfc_pkg::*;

	localparam int JB  = job_slots(MAX_PAYLOAD);
	localparam int CW  = job_count_bits(MAX_PAYLOAD);
	localparam int BCW = $clog2(MAX_PAYLOAD + 2);

	logic [15:0]    crc_q;
	logic [BCW-1:0] bc_q;
	logic [3:0]     fc_q;
	logic [7:0]     ph_q;
	logic [7:0]     store_q [MAX_PAYLOAD];

	logic           accept;
	logic [3:0]     len4, limit4;
	logic [6:0]     devs7;
	logic [BCW-1:0] bc0, bc1, bc_n;
	logic [3:0]     fc0, fc_n, dev;
	logic [15:0]    crc0, crc1, crc_n, crc_fed, pec_chk, pec_gen;
	logic [7:0]     ph_n;
	logic           err, store_we;
	logic [JB*8-1:0] chk_bytes, job_bytes;
	logic [CW-1:0]  job_count;
	logic [2:0]     job_start;
	logic           job_err;

	assign accept   = in_valid && !in_stall;
	assign in_stall = q_full;

	// payload snapshot for a check-mode request, zeroed on a PEC mismatch
	for (genvar i = 0; i < JB; i++) begin : g_chk
		if (i < MAX_PAYLOAD) begin : g_st
			assign chk_bytes[i*8 +: 8] = err ? 8'd0 : store_q[i];
		end else begin : g_pad
			assign chk_bytes[i*8 +: 8] = 8'd0;
		end
	end

	always_comb begin
		len4 = {1'b0, cfg.data_length};
		if (len4 == 4'd0) len4 = 4'd1;
		if (len4 > 4'(MAX_PAYLOAD)) len4 = 4'(MAX_PAYLOAD);
		devs7 = {2'd0, cfg.chain_devices};
		if (devs7 == 7'd0) devs7 = 7'd1;
		if (devs7 > 7'(MAX_CHAIN)) devs7 = 7'(MAX_CHAIN);

		bc0  = chain_start ? '0 : bc_q;
		fc0  = chain_start ? 4'd0 : fc_q;
		crc0 = chain_start ? PEC_SEED : crc_q;

		limit4 = (cfg.frame_mode == MODE_GENERATE) ? len4 - 4'd1 : len4 + 4'd1;
		bc1  = bc0;
		crc1 = crc0;
		// counter left past the frame end by a length/mode change: restart frame
		if (4'(bc0) > limit4) begin
			bc1  = '0;
			crc1 = PEC_SEED;
		end

		dev     = devs7[3:0] - 4'd1 - fc0;
		crc_fed = crc_feed(crc1, data_byte);
		pec_chk = {crc1[14:0], 1'b0};
		pec_gen = {crc_fed[14:0], 1'b0};
		err     = {ph_q, data_byte} != pec_chk;

		bc_n      = bc1;
		crc_n     = crc1;
		fc_n      = fc0;
		ph_n      = ph_q;
		store_we  = 1'b0;
		job_push  = 1'b0;
		job_bytes = '0;
		job_count = CW'(1);
		job_start = 3'(bc1);
		job_err   = 1'b0;

		if (cfg.frame_mode == MODE_CHECK) begin
			if (4'(bc1) < len4) begin
				store_we = 1'b1;
				crc_n    = crc_fed;
				bc_n     = bc1 + BCW'(1);
			end else if (4'(bc1) == len4) begin
				ph_n = data_byte;
				bc_n = bc1 + BCW'(1);
			end else begin
				job_push  = accept;
				job_bytes = chk_bytes;
				job_count = CW'(len4);
				job_start = 3'd0;
				job_err   = err;
				bc_n      = '0;
				crc_n     = PEC_SEED;
				fc_n      = fc0 + 4'd1;
			end
		end else begin
			job_push        = accept;
			crc_n           = crc_fed;
			job_bytes[7:0]  = data_byte;
			if (4'(bc1) == len4 - 4'd1) begin
				job_bytes[15:8]  = pec_gen[15:8];
				job_bytes[23:16] = pec_gen[7:0];
				job_count        = CW'(3);
				bc_n             = '0;
				crc_n            = PEC_SEED;
				fc_n             = fc0 + 4'd1;
			end else begin
				bc_n = bc1 + BCW'(1);
			end
		end
	end

	assign job_data = {job_err, dev, job_start, job_count, job_bytes};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= PEC_SEED;
			bc_q  <= '0;
			fc_q  <= 4'd0;
			ph_q  <= 8'd0;
		end else if (accept) begin
			crc_q <= crc_n;
			bc_q  <= bc_n;
			fc_q  <= fc_n;
			ph_q  <= ph_n;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_PAYLOAD; i++) begin
			if (accept && store_we && bc1 == BCW'(i)) store_q[i] <= data_byte;
		end
	end

endmodule

@@ hw/rtl/pfc_fifo.sv @@
// Request queue between front and back ends; register array with counters.
// Uses pfc_pkg for the default depth.
module pfc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = pfc_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);
	import pfc_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [NW-1:0]    cnt_q;

	assign full       = cnt_q == NW'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			if (pop)  rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			if (push && !pop) cnt_q <= cnt_q + NW'(1);
			else if (pop && !push) cnt_q <= cnt_q - NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_valid)) else $error("pop from empty queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(DEPTH)) else $error("queue count past depth");

endmodule

@@ hw/rtl/pfc_back.sv @@
// Back end: walks the head request one result per cycle, while the output is not stalled, into the output register.
// Uses pfc_pkg for the request layout.
module pfc_back #(
	parameter int MAX_PAYLOAD = pfc_pkg::MAX_PAYLOAD
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     head_valid,
	input  logic [pfc_pkg::job_width(MAX_PAYLOAD)-1:0] head_data,
	output logic                                     pop,
	input  logic                                     out_stall,
	output logic                                     out_valid,
	output logic [7:0]                               byte_out,
	output logic [2:0]                               byte_index,
	output logic [3:0]                               device_index,
	output logic                                     pec_error,
	output logic                                     last
);
	import pfc_pkg::*;

	localparam int JB = job_slots(MAX_PAYLOAD);
	localparam int CW = job_count_bits(MAX_PAYLOAD);
	localparam int KW = $clog2(JB);
	localparam int BO = JB * 8;

	logic [KW-1:0] k_q;
	logic [CW-1:0] count;
	logic [2:0]    start;
	logic [3:0]    dev;
	logic          err, load, is_last;
	logic [7:0]    sel;

	assign count = head_data[BO +: CW];
	assign start = head_data[BO+CW +: 3];
	assign dev   = head_data[BO+CW+3 +: 4];
	assign err   = head_data[BO+CW+7];

	always_comb begin
		sel = 8'd0;
		for (int j = 0; j < JB; j++) begin
			if (k_q == KW'(j)) sel = head_data[j*8 +: 8];
		end
	end

	assign load    = head_valid && (!out_valid || !out_stall);
	assign is_last = CW'(k_q) == count - CW'(1);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load) k_q <= is_last ? '0 : k_q + KW'(1);
			if (load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_out     <= sel;
			byte_index   <= start + 3'(k_q);
			device_index <= dev;
			pec_error    <= err;
			last         <= is_last;
		end
	end

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> CW'(k_q) < count) else $error("cursor past request count");
	a_cursor_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> k_q == '0) else $error("cursor not cleared between requests");
	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid && last) else $error("request retired without final result");

endmodule

@@ hw/rtl/pec15_frame_checker_top.sv @@
// PEC-15 frame checker/generator, top level. Uses pfc_pkg, pfc_front, pfc_fifo, pfc_back.
// A result reaches the output through the request queue and then the output register.
// Throughput: one byte accepted per cycle unless the queue is full, one result delivered
//   per cycle while not stalled; the front CRC step is one table lookup and xor per byte.
// Generate frames yield len+2 results for len bytes, so input stalls while the queue is full.
// Reset (arst_n low, async): config to check mode / length 6 / one device, remainder to the
//   seed, counters and queue cleared, output empty. No clearing pass is needed.
module pec15_frame_checker_top #(
	parameter int MAX_PAYLOAD = pfc_pkg::MAX_PAYLOAD,
	parameter int MAX_CHAIN   = pfc_pkg::MAX_CHAIN,
	parameter int QUEUE_DEPTH = pfc_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration write port
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_data,
	// byte input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       chain_start,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] byte_out,
	output logic [2:0] byte_index,
	output logic [3:0] device_index,
	output logic       pec_error,
	output logic       last
);
	import pfc_pkg::*;

	localparam int JW = job_width(MAX_PAYLOAD);

	cfg_t          cfg_q;
	logic          q_full, job_push, head_valid, pop;
	logic [JW-1:0] job_data, head_data;

	// Config registers; writes to an unlisted index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_mode    <= MODE_CHECK;
			cfg_q.data_length   <= 3'd6;
			cfg_q.chain_devices <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_MODE:    cfg_q.frame_mode    <= cfg_data[0];
				REG_DATA_LENGTH:   cfg_q.data_length   <= cfg_data[2:0];
				REG_CHAIN_DEVICES: cfg_q.chain_devices <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: classifies each byte, keeps remainder/counters/payload, queues a request
	// for any byte that produces results (whole payload, or echo plus PEC bytes).
	pfc_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.MAX_CHAIN  (MAX_CHAIN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.chain_start(chain_start),
		.q_full     (q_full),
		.job_push   (job_push),
		.job_data   (job_data)
	);

	// Short queue decouples byte intake from result delivery.
	pfc_fifo #(
		.WIDTH(JW),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_data),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_data (head_data)
	);

	// Back: unrolls the head request into individual results, registered output.
	pfc_back #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_data   (head_data),
		.pop         (pop),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.byte_out    (byte_out),
		.byte_index  (byte_index),
		.device_index(device_index),
		.pec_error   (pec_error),
		.last        (last)
	);

endmodule

@@ bench/pec15_frame_checker_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for pec15_frame_checker_top: drives byte requests through a
// queue-fed driver and checks every result against a PEC-15 frame predictor. Uses pfc_pkg.
module pec15_frame_checker_top_tb;
	import pfc_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 6;
	localparam int LONG_HOLD = 80;

	typedef struct packed {
		logic [7:0] data;
		logic       restart;
	} stream_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] index;
		logic [3:0] device;
		logic       err_flag;
		logic       is_last;
	} frame_byte_t;

	// DUT ports, inputs known from time zero
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [4:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = '0;
	logic       chain_start = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] byte_out;
	logic [2:0] byte_index;
	logic [3:0] device_index;
	logic       pec_error;
	logic       last;

	// request queue filled by the sequence, drained by the driver
	stream_item_t stream_q[$];
	frame_byte_t  expected_bytes[$];
	int           bytes_queued = 0;
	int           fails = 0;
	int unsigned  cycle_count = 0;

	// pacing controls for the driver and the monitor
	logic idle_en = 1'b1;
	logic rx_hold_req = 1'b0;
	logic rx_hold_done = 1'b0;
	int   send_gap = 0;
	int   rx_stall_left = 0;
	stream_item_t drive_item;
	frame_byte_t  want;

	// predictor copy of the registers and of the frame state
	logic       mode_sh = MODE_CHECK;
	logic [2:0] len_sh = 3'd6;
	logic [4:0] chain_sh = 5'd1;
	logic [15:0] pec_crc = PEC_SEED;
	int          frame_pos = 0;
	logic [3:0]  frame_num = '0;
	logic [7:0]  payload_mem [MAX_PAYLOAD];
	logic [7:0]  rx_pec_hi = '0;

	pec15_frame_checker_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.chain_start(chain_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.byte_out(byte_out),
		.byte_index(byte_index),
		.device_index(device_index),
		.pec_error(pec_error),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Out-of-range length acts as the nearest legal one.
	function automatic int eff_length(input logic [2:0] raw);
		if (raw == 0) return 1;
		if (raw > MAX_PAYLOAD) return MAX_PAYLOAD;
		return raw;
	endfunction

	// One byte through the PEC-15 remainder (poly 0x4599), table form unrolled.
	function automatic logic [15:0] pec_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] t;
		t = {1'b0, crc[14:7] ^ b, 7'd0};
		repeat (8) t = t[14] ? ({t[14:0], 1'b0} ^ PEC_POLY) : {t[14:0], 1'b0};
		return {crc[7:0], 8'h00} ^ t;
	endfunction

	// Bias toward the all-zero and all-one bytes.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: begin
				return 8'h00;
			end
			1: begin
				return 8'hFF;
			end
			default: begin
				return 8'($urandom_range(0, 255));
			end
		endcase
	endfunction

	task automatic add_result(input logic [7:0] d, input int idx, input logic [3:0] dev,
			input logic err, input logic lst);
		frame_byte_t r;
		r.data = d;
		r.index = 3'(idx);
		r.device = dev;
		r.err_flag = err;
		r.is_last = lst;
		expected_bytes.push_back(r);
	endtask

	// Frame done: counters restart, frame number advances mod 16.
	task automatic close_frame();
		frame_pos = 0;
		pec_crc = PEC_SEED;
		frame_num = frame_num + 4'd1;
	endtask

	// Expected results for one accepted byte request.
	task automatic predict_byte(input logic [7:0] b, input logic restart);
		int len;
		int devs;
		int limit;
		logic [3:0] dev;
		logic [15:0] word;
		logic err;
		len = eff_length(len_sh);
		devs = (chain_sh == 0) ? 1 : ((chain_sh > MAX_CHAIN) ? MAX_CHAIN : chain_sh);
		if (restart) begin
			frame_pos = 0;
			frame_num = '0;
			pec_crc = PEC_SEED;
		end
		// a config change can leave the position past the frame end: restart the frame
		limit = (mode_sh == MODE_GENERATE) ? len - 1 : len + 1;
		if (frame_pos > limit) begin
			frame_pos = 0;
			pec_crc = PEC_SEED;
		end
		dev = 4'(devs - 1 - int'(frame_num));
		if (mode_sh == MODE_CHECK) begin
			if (frame_pos < len) begin
				payload_mem[frame_pos] = b;
				pec_crc = pec_next(pec_crc, b);
				frame_pos++;
			end else if (frame_pos == len) begin
				rx_pec_hi = b;
				frame_pos++;
			end else begin
				word = {pec_crc[14:0], 1'b0};
				err = ({rx_pec_hi, b} != word);
				for (int i = 0; i < len; i++)
					add_result(err ? 8'h00 : payload_mem[i], i, dev, err, i == len - 1);
				close_frame();
			end
		end else begin
			pec_crc = pec_next(pec_crc, b);
			if (frame_pos == len - 1) begin
				word = {pec_crc[14:0], 1'b0};
				add_result(b, frame_pos, dev, 1'b0, 1'b0);
				add_result(word[15:8], len, dev, 1'b0, 1'b0);
				add_result(word[7:0], len + 1, dev, 1'b0, 1'b1);
				close_frame();
			end else begin
				add_result(b, frame_pos, dev, 1'b0, 1'b1);
				frame_pos++;
			end
		end
	endtask

	// Driver: holds a stalled request, otherwise offers the next queued byte or a gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= '0;
			chain_start <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall)
				predict_byte(data_byte, chain_start);
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (stream_q.size() > 0) begin
					drive_item = stream_q.pop_front();
					in_valid <= 1'b1;
					data_byte <= drive_item.data;
					chain_start <= drive_item.restart;
					if (idle_en && $urandom_range(0, 6) == 0)
						send_gap = $urandom_range(1, 18);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result, and drives stall bursts plus the one long hold.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected result: byte_out %0h byte_index %0d", byte_out, byte_index);
					fails++;
				end else begin
					want = expected_bytes.pop_front();
					if (byte_out !== want.data) begin
						$error("byte_out: expected %0h, got %0h", want.data, byte_out);
						fails++;
					end
					if (byte_index !== want.index) begin
						$error("byte_index: expected %0d, got %0d", want.index, byte_index);
						fails++;
					end
					if (device_index !== want.device) begin
						$error("device_index: expected %0d, got %0d", want.device, device_index);
						fails++;
					end
					if (pec_error !== want.err_flag) begin
						$error("pec_error: expected %0b, got %0b", want.err_flag, pec_error);
						fails++;
					end
					if (last !== want.is_last) begin
						$error("last: expected %0b, got %0b", want.is_last, last);
						fails++;
					end
				end
			end
			// long hold: sender keeps going, so the block has to back up and stall its input
			if (rx_hold_req && !rx_hold_done) begin
				rx_hold_done = 1'b1;
				rx_stall_left = LONG_HOLD;
			end
			if (rx_stall_left > 0) begin
				rx_stall_left--;
				out_stall <= 1'b1;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				rx_stall_left = $urandom_range(1, 18) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic restart);
		stream_item_t it;
		it.data = b;
		it.restart = restart;
		stream_q.push_back(it);
		bytes_queued++;
	endtask

	// Check-mode frame: n payload bytes (byte 0 in the low lane), then the PEC word
	// high byte first; flip corrupts the PEC.
	task automatic queue_check_frame(input logic [8*MAX_PAYLOAD-1:0] body, input int n,
			input logic restart, input logic [15:0] flip);
		logic [15:0] crc;
		logic [15:0] word;
		crc = PEC_SEED;
		for (int i = 0; i < n; i++) begin
			crc = pec_next(crc, body[8*i +: 8]);
			push_byte(body[8*i +: 8], (i == 0) ? restart : 1'b0);
		end
		word = {crc[14:0], 1'b0} ^ flip;
		push_byte(word[15:8], 1'b0);
		push_byte(word[7:0], 1'b0);
	endtask

	// Sender pause: nothing queued, nothing offered, nothing outstanding.
	task automatic wait_idle();
		while (stream_q.size() != 0 || in_valid || expected_bytes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [4:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_FRAME_MODE: begin
				mode_sh = val[0];
			end
			REG_DATA_LENGTH: begin
				len_sh = val[2:0];
			end
			default: begin
				chain_sh = val;
			end
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic mode, input logic [2:0] len, input logic [4:0] chain);
		write_reg(REG_FRAME_MODE, {4'd0, mode});
		write_reg(REG_DATA_LENGTH, {2'd0, len});
		write_reg(REG_CHAIN_DEVICES, chain);
		@(negedge clk);
	endtask

	// Mostly well-formed frames with random content; some corrupted PECs, some noise.
	// A partial frame may be left behind so the next setting sees a stale position.
	task automatic random_phase(input logic mode, input logic [2:0] len, input logic [4:0] chain,
			input int nbytes, input logic idle);
		int eff;
		int start;
		int roll;
		int k;
		logic realign;
		logic [8*MAX_PAYLOAD-1:0] body;
		set_config(mode, len, chain);
		idle_en = idle;
		eff = eff_length(len);
		start = bytes_queued;
		realign = 1'b1;
		while (bytes_queued - start < nbytes) begin
			roll = $urandom_range(0, 99);
			for (int i = 0; i < MAX_PAYLOAD; i++)
				body[8*i +: 8] = pick_byte();
			if (mode == MODE_CHECK && roll < 85) begin
				queue_check_frame(body, eff, realign || $urandom_range(0, 4) == 0,
					(roll < 72) ? 16'h0000 : (16'h0001 << $urandom_range(0, 15)));
				realign = 1'b0;
			end else if (mode == MODE_GENERATE && roll < 88) begin
				for (int i = 0; i < eff; i++)
					push_byte(body[8*i +: 8], (i == 0) && ($urandom_range(0, 5) == 0));
			end else begin
				// noise or a truncated frame; check frames realign with chain_start afterwards
				k = $urandom_range(1, eff + 1);
				for (int i = 0; i < k; i++)
					push_byte(pick_byte(), $urandom_range(0, 3) == 0);
				realign = 1'b1;
			end
		end
		if ($urandom_range(0, 2) == 0) begin
			k = $urandom_range(1, 3);
			for (int i = 0; i < k; i++)
				push_byte(pick_byte(), 1'b0);
		end
		wait_idle();
	endtask

	initial begin
		for (int i = 0; i < MAX_PAYLOAD; i++)
			payload_mem[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset setting (check, six bytes, one device). This first full frame writes
		// every payload entry, so later outputs never show an unwritten one.
		queue_check_frame(48'hAA_7F_01_80_FF_00, 6, 1'b1, 16'h0000);
		wait_idle();

		// Zero length and zero chain act as one: device index wraps below zero.
		// Good frame, bad PEC frame, then stop after the PEC high byte.
		set_config(MODE_CHECK, 3'd0, 5'd0);
		queue_check_frame(48'h5A, 1, 1'b0, 16'h0000);
		queue_check_frame(48'hC3, 1, 1'b0, 16'h0001);
		push_byte(8'h3C, 1'b0);
		push_byte(8'h12, 1'b0);
		wait_idle();

		// Generate with length 2: stale position is past the frame end, so it restarts.
		// chain_start mid-stream in generate mode too.
		set_config(MODE_GENERATE, 3'd2, 5'd16);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h81, 1'b1);
		push_byte(8'h7E, 1'b0);
		wait_idle();

		// Twenty one-byte frames with no restart: frame count wraps past 16; chain clamps.
		set_config(MODE_GENERATE, 3'd0, 5'd31);
		for (int i = 0; i < 20; i++)
			push_byte(pick_byte(), 1'b0);
		wait_idle();

		random_phase(MODE_CHECK, 3'd7, 5'd16, 12, 1'b1);

		// Back-pressure: receiver holds off while the sender streams without gaps.
		set_config(MODE_GENERATE, 3'd6, 5'd17);
		idle_en = 1'b0;
		rx_hold_req = 1'b1;
		for (int i = 0; i < 18; i++)
			push_byte(pick_byte(), 1'b0);
		wait_idle();

		for (int p = 0; p < 4; p++)
			random_phase(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
				5'($urandom_range(0, 31)), 6, p < 2);

		wait_idle();
		repeat (20) @(negedge clk);
		if (fails == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/pfc_pkg.sv
hw/rtl/pfc_front.sv
hw/rtl/pfc_fifo.sv
hw/rtl/pfc_back.sv
hw/rtl/pec15_frame_checker_top.sv
bench/pec15_frame_checker_top_tb.sv
